### rtl/uart_8250_register_model_macros.svh
`ifndef UART_8250_REGISTER_MODEL_MACROS_SVH
`define UART_8250_REGISTER_MODEL_MACROS_SVH

// same-cycle check, sampled on clk, off while rst_n is low
`define U8250_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check, sampled on clk, off while rst_n is low
`define U8250_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/u8250_pkg.sv
`timescale 1ns / 1ps

package u8250_pkg;

    localparam int MODE_W = 2;
    localparam int OFF_W  = 3;
    localparam int BYTE_W = 8;
    localparam int CAUSE_W = 2;
    localparam int NUM_CAUSES = 4;

    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RX    = 2'd2;

    localparam logic [OFF_W-1:0] OFF_DATA = 3'd0;
    localparam logic [OFF_W-1:0] OFF_IER  = 3'd1;
    localparam logic [OFF_W-1:0] OFF_IIR  = 3'd2;
    localparam logic [OFF_W-1:0] OFF_LCR  = 3'd3;
    localparam logic [OFF_W-1:0] OFF_MCR  = 3'd4;
    localparam logic [OFF_W-1:0] OFF_LSR  = 3'd5;
    localparam logic [OFF_W-1:0] OFF_MSR  = 3'd6;
    localparam logic [OFF_W-1:0] OFF_SCR  = 3'd7;

    localparam logic [CAUSE_W-1:0] CAUSE_MODEM = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_TX    = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_RX    = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_LINE  = 2'd3;

    localparam int DLAB_BIT   = 7;
    localparam int IER_RX_BIT = 0;
    localparam int IER_TX_BIT = 1;

    localparam logic [BYTE_W-1:0] LSR_RESET = 8'h60;
    localparam logic [BYTE_W-1:0] MSR_VALUE = 8'h90;
    localparam logic [BYTE_W-1:0] DLL_RESET = 8'h01;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [OFF_W-1:0]  reg_offset;
        logic [BYTE_W-1:0] write_data;
    } u8250_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              irq_pulse;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
    } u8250_result_t;

    typedef struct packed {
        logic [CAUSE_W-1:0]    cause;
        logic                  none;
        logic [NUM_CAUSES-1:0] queue;
    } u8250_irq_t;

    function automatic u8250_irq_t irq_raise(u8250_irq_t s, logic [CAUSE_W-1:0] c);
        u8250_irq_t r;
        r = s;
        if (!s.none)
        begin
            r.queue[c] = 1'b1;
        end
        else
        begin
            r.cause = c;
            r.none  = 1'b0;
        end
        return r;
    endfunction

    function automatic u8250_irq_t irq_pop(u8250_irq_t s);
        u8250_irq_t r;
        r = s;
        if (s.queue == '0)
        begin
            r.none = 1'b1;
        end
        else
        begin
            r.none = 1'b0;
            if (s.queue[0])
            begin
                r.cause = CAUSE_MODEM;
            end
            else if (s.queue[1])
            begin
                r.cause = CAUSE_TX;
            end
            else if (s.queue[2])
            begin
                r.cause = CAUSE_RX;
            end
            else
            begin
                r.cause = CAUSE_LINE;
            end
            r.queue[r.cause] = 1'b0;
        end
        return r;
    endfunction

    function automatic u8250_irq_t irq_drop(u8250_irq_t s, logic [CAUSE_W-1:0] c);
        u8250_irq_t r;
        r = s;
        r.queue[c] = 1'b0;
        if (s.cause == c)
        begin
            r = irq_pop(r);
        end
        return r;
    endfunction

endpackage

### rtl/u8250_req_if.sv
`timescale 1ns / 1ps

interface u8250_req_if import u8250_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [OFF_W-1:0]  reg_offset;
    logic [BYTE_W-1:0] write_data;

    modport source (output valid, output mode, output reg_offset, output write_data,
                    input ready);
    modport sink (input valid, input mode, input reg_offset, input write_data,
                  output ready);
endinterface

### rtl/u8250_rsp_if.sv
`timescale 1ns / 1ps

interface u8250_rsp_if import u8250_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              irq_pulse;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;

    modport source (output valid, output read_data, output irq_pulse, output tx_valid,
                    output tx_byte, input ready);
    modport sink (input valid, input read_data, input irq_pulse, input tx_valid,
                  input tx_byte, output ready);
endinterface

### rtl/u8250_regs.sv
`timescale 1ns / 1ps

`include "uart_8250_register_model_macros.svh"

module u8250_regs import u8250_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  u8250_item_t   item,
    output u8250_result_t result
);

    logic [BYTE_W-1:0] ier_reg, ier_next;
    u8250_irq_t        irq_reg, irq_next;
    logic [BYTE_W-1:0] lcr_reg, lcr_next;
    logic [BYTE_W-1:0] mcr_reg, mcr_next;
    logic              dr_reg, dr_next;
    logic [BYTE_W-1:0] dll_reg, dll_next;
    logic [BYTE_W-1:0] dlm_reg, dlm_next;
    logic [BYTE_W-1:0] rbr_reg, rbr_next;

    logic dlab;

    assign dlab = lcr_reg[DLAB_BIT];

    always_comb
    begin
        ier_next = ier_reg;
        irq_next = irq_reg;
        lcr_next = lcr_reg;
        mcr_next = mcr_reg;
        dr_next  = dr_reg;
        dll_next = dll_reg;
        dlm_next = dlm_reg;
        rbr_next = rbr_reg;
        result   = '0;

        unique case (item.mode)
            MODE_READ:
            begin
                unique case (item.reg_offset)
                    OFF_DATA:
                    begin
                        if (dlab)
                        begin
                            result.read_data = dll_reg;
                        end
                        else
                        begin
                            result.read_data = rbr_reg;
                            dr_next = 1'b0;
                        end
                    end
                    OFF_IER: result.read_data = dlab ? dlm_reg : ier_reg;
                    OFF_IIR:
                    begin
                        result.read_data = {{(BYTE_W-CAUSE_W-1){1'b0}}, irq_reg.cause,
                                            irq_reg.none};
                        result.irq_pulse = |irq_reg.queue;
                        irq_next = irq_pop(irq_reg);
                    end
                    OFF_LCR: result.read_data = lcr_reg;
                    OFF_MCR: result.read_data = mcr_reg;
                    OFF_LSR: result.read_data = {LSR_RESET[BYTE_W-1:1], dr_reg};
                    OFF_MSR: result.read_data = MSR_VALUE;
                    default: result.read_data = '0;
                endcase
            end
            MODE_WRITE:
            begin
                unique case (item.reg_offset)
                    OFF_DATA:
                    begin
                        if (dlab)
                        begin
                            dll_next = item.write_data;
                        end
                        else
                        begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = item.write_data;
                            if (ier_reg[IER_TX_BIT])
                            begin
                                result.irq_pulse = irq_reg.none;
                                irq_next = irq_raise(irq_reg, CAUSE_TX);
                            end
                        end
                    end
                    OFF_IER:
                    begin
                        if (dlab)
                        begin
                            dlm_next = item.write_data;
                        end
                        else
                        begin
                            ier_next = item.write_data;
                            if (item.write_data[IER_TX_BIT] && !ier_reg[IER_TX_BIT])
                            begin
                                result.irq_pulse = result.irq_pulse | irq_next.none;
                                irq_next = irq_raise(irq_next, CAUSE_TX);
                            end
                            else if (!item.write_data[IER_TX_BIT] && ier_reg[IER_TX_BIT])
                            begin
                                irq_next = irq_drop(irq_next, CAUSE_TX);
                            end
                            if (item.write_data[IER_RX_BIT] && !ier_reg[IER_RX_BIT])
                            begin
                                result.irq_pulse = result.irq_pulse | irq_next.none;
                                irq_next = irq_raise(irq_next, CAUSE_RX);
                            end
                            else if (!item.write_data[IER_RX_BIT] && ier_reg[IER_RX_BIT])
                            begin
                                irq_next = irq_drop(irq_next, CAUSE_RX);
                            end
                        end
                    end
                    OFF_LCR: lcr_next = item.write_data;
                    OFF_MCR: mcr_next = item.write_data;
                    default:
                    begin
                    end
                endcase
            end
            MODE_RX:
            begin
                if (!dr_reg)
                begin
                    rbr_next = item.write_data;
                    dr_next  = 1'b1;
                    if (ier_reg[IER_RX_BIT])
                    begin
                        result.irq_pulse = irq_reg.none;
                        irq_next = irq_raise(irq_reg, CAUSE_RX);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ier_reg <= '0;
            irq_reg <= '{cause: CAUSE_MODEM, none: 1'b1, queue: '0};
            lcr_reg <= '0;
            mcr_reg <= '0;
            dr_reg  <= 1'b0;
            dll_reg <= DLL_RESET;
            dlm_reg <= '0;
            rbr_reg <= '0;
        end
        else if (fire)
        begin
            ier_reg <= ier_next;
            irq_reg <= irq_next;
            lcr_reg <= lcr_next;
            mcr_reg <= mcr_next;
            dr_reg  <= dr_next;
            dll_reg <= dll_next;
            dlm_reg <= dlm_next;
            rbr_reg <= rbr_next;
        end
    end

    `U8250_ASSERT_NOW(a_none_means_empty, irq_reg.none, irq_reg.queue == '0, "pending causes queued while iir shows none")
    `U8250_ASSERT_NEXT(a_rx_overrun_keeps, fire && item.mode == MODE_RX && dr_reg, $stable(rbr_reg) && dr_reg, "received byte overwrote a waiting byte")
    `U8250_ASSERT_NEXT(a_pulse_shows_cause, fire && result.irq_pulse, !irq_reg.none, "interrupt pulsed but no cause shown")

endmodule

### rtl/uart_8250_register_model.sv
`timescale 1ns / 1ps

// 8250-style uart register block, single port
//
// req channel: one transaction per bus read, bus write (offset 0-7) or byte
// received from the serial line (mode 2). rsp channel: exactly one
// transaction per req transaction, in order, carrying read data, an
// interrupt pulse flag and the transmitted byte, if any.
//
// a req accepted into the input stage is passed through the register update into
// the result register and offered on rsp from then on. throughput: one
// transaction per cycle while rsp does not stall; the register update between
// the input stage and the result register is combinational.
//
// reset: all registers take their 8250 power-on values, iir reads "no
// interrupt", both stages empty.
// when rsp stalls, the result register holds; one more req is still taken
// into the input stage, after which req.ready drops until rsp drains.

module uart_8250_register_model import u8250_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    u8250_req_if.sink   req,
    u8250_rsp_if.source rsp
);

    logic          in_valid_reg;
    u8250_item_t   in_item_reg;
    logic          out_valid_reg;
    u8250_result_t out_result_reg;
    u8250_result_t result;
    logic          advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    u8250_regs u_regs
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg <= '{mode: req.mode, reg_offset: req.reg_offset,
                             write_data: req.write_data};
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_result_reg.read_data;
    assign rsp.irq_pulse = out_result_reg.irq_pulse;
    assign rsp.tx_valid  = out_result_reg.tx_valid;
    assign rsp.tx_byte   = out_result_reg.tx_byte;

endmodule

### bench/tb_uart_8250_register_model.sv
`timescale 1ns / 1ps

module tb_uart_8250_register_model;
    import u8250_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;
    localparam int IDLE_PCT     = 38;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 5;

    class uart_scoreboard;
        logic [BYTE_W-1:0]     ier;
        logic [BYTE_W-1:0]     lcr;
        logic [BYTE_W-1:0]     mcr;
        logic [BYTE_W-1:0]     lsr;
        logic [BYTE_W-1:0]     msr;
        logic [BYTE_W-1:0]     dll;
        logic [BYTE_W-1:0]     dlh;
        logic [BYTE_W-1:0]     rbr;
        logic [CAUSE_W-1:0]    shown_cause;
        logic                  no_irq;
        logic [NUM_CAUSES-1:0] waiting_causes;
        u8250_result_t         expected_q[$];
        int                    errors;

        function new();
            ier            = '0;
            lcr            = '0;
            mcr            = '0;
            lsr            = LSR_RESET;
            msr            = MSR_VALUE;
            dll            = DLL_RESET;
            dlh            = '0;
            rbr            = '0;
            shown_cause    = '0;
            no_irq         = 1'b1;
            waiting_causes = '0;
            errors         = 0;
        endfunction

        // show a cause if none is shown, else queue it; returns the pulse
        function logic raise(logic [CAUSE_W-1:0] c);
            if (!no_irq)
            begin
                waiting_causes[c] = 1'b1;
                return 1'b0;
            end
            shown_cause = c;
            no_irq      = 1'b0;
            return 1'b1;
        endfunction

        function logic pop_next();
            int first;
            if (waiting_causes == '0)
            begin
                no_irq = 1'b1;
                return 1'b0;
            end
            first = 0;
            for (int b = NUM_CAUSES - 1; b >= 0; b--)
            begin
                if (waiting_causes[b])
                begin
                    first = b;
                end
            end
            waiting_causes[first] = 1'b0;
            shown_cause           = CAUSE_W'(first);
            no_irq                = 1'b0;
            return 1'b1;
        endfunction

        function void drop(logic [CAUSE_W-1:0] c);
            waiting_causes[c] = 1'b0;
            if (shown_cause == c)
            begin
                void'(pop_next());
            end
        endfunction

        function u8250_result_t predict(u8250_item_t it);
            u8250_result_t r;
            logic          dlab;
            logic [BYTE_W-1:0] old_ier;
            r    = '0;
            dlab = lcr[DLAB_BIT];
            case (it.mode)
                MODE_READ:
                begin
                    case (it.reg_offset)
                        OFF_DATA:
                        begin
                            if (dlab)
                            begin
                                r.read_data = dll;
                            end
                            else
                            begin
                                r.read_data = rbr;
                                lsr[0]      = 1'b0;
                            end
                        end
                        OFF_IER: r.read_data = dlab ? dlh : ier;
                        OFF_IIR:
                        begin
                            r.read_data = {5'b0, shown_cause, no_irq};
                            r.irq_pulse = pop_next();
                        end
                        OFF_LCR: r.read_data = lcr;
                        OFF_MCR: r.read_data = mcr;
                        OFF_LSR: r.read_data = lsr;
                        OFF_MSR: r.read_data = msr;
                        default: r.read_data = '0;
                    endcase
                end
                MODE_WRITE:
                begin
                    case (it.reg_offset)
                        OFF_DATA:
                        begin
                            if (dlab)
                            begin
                                dll = it.write_data;
                            end
                            else
                            begin
                                r.tx_valid = 1'b1;
                                r.tx_byte  = it.write_data;
                                if (ier[IER_TX_BIT])
                                begin
                                    r.irq_pulse = raise(CAUSE_TX);
                                end
                            end
                        end
                        OFF_IER:
                        begin
                            if (dlab)
                            begin
                                dlh = it.write_data;
                            end
                            else
                            begin
                                old_ier = ier;
                                ier     = it.write_data;
                                if (ier[IER_TX_BIT] && !old_ier[IER_TX_BIT])
                                begin
                                    r.irq_pulse = raise(CAUSE_TX) | r.irq_pulse;
                                end
                                else if (!ier[IER_TX_BIT] && old_ier[IER_TX_BIT])
                                begin
                                    drop(CAUSE_TX);
                                end
                                if (ier[IER_RX_BIT] && !old_ier[IER_RX_BIT])
                                begin
                                    r.irq_pulse = raise(CAUSE_RX) | r.irq_pulse;
                                end
                                else if (!ier[IER_RX_BIT] && old_ier[IER_RX_BIT])
                                begin
                                    drop(CAUSE_RX);
                                end
                            end
                        end
                        OFF_LCR: lcr = it.write_data;
                        OFF_MCR: mcr = it.write_data;
                        default: ;
                    endcase
                end
                MODE_RX:
                begin
                    if (!lsr[0])
                    begin
                        rbr    = it.write_data;
                        lsr[0] = 1'b1;
                        if (ier[IER_RX_BIT])
                        begin
                            r.irq_pulse = raise(CAUSE_RX);
                        end
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_item(u8250_item_t it);
            expected_q.push_back(predict(it));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(u8250_result_t got);
            u8250_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected transaction %h", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.read_data !== want.read_data)
            begin
                report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
            end
            if (got.irq_pulse !== want.irq_pulse)
            begin
                report($sformatf("irq_pulse %b, want %b", got.irq_pulse, want.irq_pulse));
            end
            if (got.tx_valid !== want.tx_valid)
            begin
                report($sformatf("tx_valid %b, want %b", got.tx_valid, want.tx_valid));
            end
            if (got.tx_byte !== want.tx_byte)
            begin
                report($sformatf("tx_byte %h, want %h", got.tx_byte, want.tx_byte));
            end
        endtask

        task drain_check();
            if (expected_q.size() != 0)
            begin
                report($sformatf("%0d transactions never returned", expected_q.size()));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic calm;
    int   quiet_cycles;
    uart_scoreboard sb;

    u8250_req_if req_ch ();
    u8250_rsp_if rsp_ch ();

    uart_8250_register_model DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            sb.check_result({rsp_ch.read_data, rsp_ch.irq_pulse, rsp_ch.tx_valid,
                             rsp_ch.tx_byte});
        end
        rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles < STALL_LIMIT)
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        else
        begin
            $display("FAIL uart_8250_register_model");
            $finish;
        end
    end

    task automatic send(input logic [MODE_W-1:0] m, input logic [OFF_W-1:0] o,
                        input logic [BYTE_W-1:0] d);
        u8250_item_t it;
        int          gap;
        it  = {m, o, d};
        gap = 0;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= it.mode;
        req_ch.reg_offset <= it.reg_offset;
        req_ch.write_data <= it.write_data;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_item(it);
    endtask

    function automatic u8250_item_t random_item();
        u8250_item_t it;
        int          pick;
        pick          = $urandom_range(99);
        it.write_data = BYTE_W'($urandom_range(255));
        it.reg_offset = OFF_W'($urandom_range(7));
        if (pick < 35)
        begin
            it.mode = MODE_READ;
            if ($urandom_range(99) < 40)
            begin
                it.reg_offset = $urandom_range(1) ? OFF_IIR : OFF_DATA;
            end
        end
        else if (pick < 75)
        begin
            it.mode = MODE_WRITE;
            if ($urandom_range(99) < 60)
            begin
                case ($urandom_range(2))
                    0:       it.reg_offset = OFF_DATA;
                    1:       it.reg_offset = OFF_IER;
                    default: it.reg_offset = OFF_LCR;
                endcase
            end
            // keep dlab mostly clear so the data and ier paths stay busy
            if (it.reg_offset == OFF_LCR && $urandom_range(9) < 7)
            begin
                it.write_data[DLAB_BIT] = 1'b0;
            end
        end
        else if (pick < 95)
        begin
            it.mode = MODE_RX;
        end
        else
        begin
            it.mode = MODE_UNDEF;
        end
        return it;
    endfunction

    initial
    begin
        u8250_item_t it;
        sb                = new();
        rst_n             = 1'b0;
        calm              = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = MODE_READ;
        req_ch.reg_offset = OFF_DATA;
        req_ch.write_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset values of every register
        for (int o = 0; o < 8; o++)
        begin
            send(MODE_READ, OFF_W'(o), 8'h00);
        end
        // writes that change nothing
        send(MODE_WRITE, OFF_SCR, 8'hff);
        send(MODE_WRITE, OFF_LSR, 8'hff);
        send(MODE_WRITE, OFF_MSR, 8'h00);
        send(MODE_READ, OFF_SCR, 8'h00);
        send(MODE_READ, OFF_LSR, 8'h00);
        // divisor latches
        send(MODE_WRITE, OFF_LCR, 8'h80);
        send(MODE_WRITE, OFF_DATA, 8'hff);
        send(MODE_WRITE, OFF_IER, 8'hff);
        send(MODE_READ, OFF_IER, 8'h00);
        send(MODE_WRITE, OFF_LCR, 8'h00);
        // interrupt queueing, dropped byte, data read leaving rx cause
        send(MODE_WRITE, OFF_IER, 8'h03);
        send(MODE_RX, OFF_SCR, 8'haa);
        send(MODE_RX, OFF_DATA, 8'h55);
        send(MODE_READ, OFF_DATA, 8'h00);
        send(MODE_READ, OFF_IIR, 8'h00);
        send(MODE_WRITE, OFF_DATA, 8'hff);
        send(MODE_WRITE, OFF_IER, 8'h00);
        send(MODE_READ, OFF_IIR, 8'h00);
        send(MODE_UNDEF, OFF_SCR, 8'hff);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm <= (n >= 300 && n < 450);
            it = random_item();
            send(it.mode, it.reg_offset, it.write_data);
        end
        req_ch.valid <= 1'b0;
        calm         <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.drain_check();
        if (sb.errors == 0)
        begin
            $display("PASS uart_8250_register_model");
        end
        else
        begin
            $display("FAIL uart_8250_register_model");
        end
        $finish;
    end

endmodule
